// ===== design/rrtt_pkg.sv =====
package rrtt_pkg;

  localparam int unsigned DefaultMaxTasks = 256;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_FORK    = 3'd2,
    KIND_EXIT    = 3'd3,
    KIND_WAITPID = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_EMPTY       = 3'd2,
    STAT_NONE_READY  = 3'd3,
    STAT_WAIT_FAILED = 3'd4,
    STAT_NO_CURRENT  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TS_READY      = 2'd0,
    TS_RUNNING    = 2'd1,
    TS_BLOCKED    = 2'd2,
    TS_TERMINATED = 2'd3
  } task_state_e;

  typedef struct packed {
    logic [31:0] pid;
    logic [31:0] parent_pid;
    task_state_e st;
    logic        waiting;
    logic [31:0] waited_pid;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // scan request: by_pid selects pid match, else ready-and-not-waiting
  typedef struct packed {
    logic        start;
    logic        by_pid;
    logic [31:0] key;
  } scan_ctrl_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// ===== design/rrtt_ram.sv =====
module rrtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rrtt_scan.sv =====
module rrtt_scan #(
  parameter int unsigned MAX_TASKS = rrtt_pkg::DefaultMaxTasks
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrtt_pkg::scan_ctrl_t             ctrl_i,
  input  logic [$clog2(MAX_TASKS)-1:0]     first_i,
  input  logic [$clog2(MAX_TASKS+1)-1:0]   count_i,
  input  rrtt_pkg::entry_t                 rdata_i,
  output logic [$clog2(MAX_TASKS)-1:0]     raddr_o,
  output logic                             active_o,
  output rrtt_pkg::scan_stat_t             stat_o,
  output logic [$clog2(MAX_TASKS)-1:0]     index_o
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  logic          active_q;
  logic [IW-1:0] iss_idx_q;
  logic [CW-1:0] left_q;
  logic [CW-1:0] cnt_q;
  logic          by_pid_q;
  logic [31:0]   key_q;
  logic          chk_valid_q;
  logic          chk_last_q;
  logic [IW-1:0] chk_idx_q;

  logic          hit;
  logic          done;
  logic          issue;
  logic [IW:0]   nxt;
  logic [IW-1:0] iss_idx_nxt;

  // one entry compared per cycle, reads pipelined ahead of the compare through the registered RAM read
  always_comb begin
    if (by_pid_q) begin
      hit = (rdata_i.pid == key_q);
    end else begin
      hit = (rdata_i.st == rrtt_pkg::TS_READY) && !rdata_i.waiting;
    end
    done        = chk_valid_q && (hit || chk_last_q);
    issue       = active_q && !done && (left_q != '0);
    nxt         = {1'b0, iss_idx_q} + (IW+1)'(1);
    iss_idx_nxt = (nxt >= (IW+1)'(cnt_q)) ? '0 : nxt[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      iss_idx_q   <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      by_pid_q    <= 1'b0;
      key_q       <= '0;
      chk_valid_q <= 1'b0;
      chk_last_q  <= 1'b0;
      chk_idx_q   <= '0;
    end else if (ctrl_i.start) begin
      active_q    <= 1'b1;
      iss_idx_q   <= first_i;
      left_q      <= count_i;
      cnt_q       <= count_i;
      by_pid_q    <= ctrl_i.by_pid;
      key_q       <= ctrl_i.key;
      chk_valid_q <= 1'b0;
    end else if (active_q) begin
      if (done) begin
        active_q    <= 1'b0;
        chk_valid_q <= 1'b0;
      end else begin
        chk_valid_q <= issue;
        if (issue) begin
          chk_idx_q  <= iss_idx_q;
          chk_last_q <= (left_q == CW'(1));
          iss_idx_q  <= iss_idx_nxt;
          left_q     <= left_q - CW'(1);
        end
      end
    end
  end

  assign raddr_o      = iss_idx_q;
  assign active_o     = active_q;
  assign stat_o.done  = done;
  assign stat_o.found = chk_valid_q && hit;
  assign index_o      = chk_idx_q;

endmodule

// ===== design/round_robin_task_table.sv =====
// Channel   Direction  Handshake             Ports
// command   in         start_i & !busy_o     kind_i, target_pid_i
// result    out        done_o (one cycle)    status_o, new_pid_o, running_*_o, task_count_o
//
// Add, fork, undefined kinds and every error that needs no table search: result
// in the cycle after the command. Tick, waitpid and an exit with a parent search the table;
// exit and a successful waitpid then rewrite the running entry. The search reads one table entry
// per cycle through the single read port of the entry RAM.
// Reset clears the sequencer and counters only; entries are valid below task_count.
// Results cannot be stalled; busy_o drops in the cycle done_o is shown.
module round_robin_task_table #(
  parameter int unsigned MAX_TASKS = rrtt_pkg::DefaultMaxTasks
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] target_pid_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] new_pid_o,
  output logic        running_valid_o,
  output logic [7:0]  running_index_o,
  output logic [31:0] running_pid_o,
  output logic [31:0] running_parent_pid_o,
  output logic [8:0]  task_count_o
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_WB,
    S_TICK_SCAN,
    S_EXIT_SCAN,
    S_WAIT_SCAN,
    S_CUR_RD,
    S_CUR_WR
  } state_e;

  state_e              state_q, state_d;
  rrtt_pkg::kind_e     kind_q, kind_d;
  logic [31:0]         target_q, target_d;
  rrtt_pkg::status_e   status_q, status_d;
  logic [31:0]         new_pid_q, new_pid_d;
  logic                strobe_q, strobe_d;
  logic [CW-1:0]       used_q, used_d;
  logic                cur_valid_q, cur_valid_d;
  logic [IW-1:0]       cur_idx_q, cur_idx_d;
  logic [31:0]         cur_pid_q, cur_pid_d;
  logic [31:0]         cur_parent_q, cur_parent_d;
  logic [31:0]         next_pid_q, next_pid_d;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  rrtt_pkg::entry_t        ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [IW-1:0]           fsm_raddr;
  logic [rrtt_pkg::EntryW-1:0] ram_rdata;
  rrtt_pkg::entry_t        rd_entry;
  rrtt_pkg::entry_t        new_entry;

  rrtt_pkg::scan_ctrl_t    scan_ctrl;
  logic [IW-1:0]           scan_first;
  logic [IW-1:0]           scan_raddr;
  logic                    scan_active;
  rrtt_pkg::scan_stat_t    scan_stat;
  logic [IW-1:0]           scan_idx;

  logic                    full;
  logic [IW:0]             after_cur;
  logic [IW-1:0]           first_after_cur;

  assign rd_entry  = rrtt_pkg::entry_t'(ram_rdata);
  assign ram_raddr = scan_active ? scan_raddr : fsm_raddr;

  rrtt_ram #(
    .WIDTH (rrtt_pkg::EntryW),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rrtt_scan #(
    .MAX_TASKS (MAX_TASKS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (scan_ctrl),
    .first_i  (scan_first),
    .count_i  (used_q),
    .rdata_i  (rd_entry),
    .raddr_o  (scan_raddr),
    .active_o (scan_active),
    .stat_o   (scan_stat),
    .index_o  (scan_idx)
  );

  always_comb begin
    full            = (used_q >= CW'(MAX_TASKS));
    after_cur       = {1'b0, cur_idx_q} + (IW+1)'(1);
    first_after_cur = (after_cur >= (IW+1)'(used_q)) ? '0 : after_cur[IW-1:0];

    new_entry            = '0;
    new_entry.pid        = next_pid_q;
    new_entry.st         = rrtt_pkg::TS_READY;

    state_d      = state_q;
    kind_d       = kind_q;
    target_d     = target_q;
    status_d     = status_q;
    new_pid_d    = new_pid_q;
    strobe_d     = 1'b0;
    used_d       = used_q;
    cur_valid_d  = cur_valid_q;
    cur_idx_d    = cur_idx_q;
    cur_pid_d    = cur_pid_q;
    cur_parent_d = cur_parent_q;
    next_pid_d   = next_pid_q;

    ram_we     = 1'b0;
    ram_waddr  = cur_idx_q;
    ram_wdata  = rd_entry;
    fsm_raddr  = cur_idx_q;
    scan_ctrl  = '0;
    scan_first = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d    = rrtt_pkg::kind_e'(kind_i);
          target_d  = target_pid_i;
          status_d  = rrtt_pkg::STAT_OK;
          new_pid_d = '0;
          unique case (rrtt_pkg::kind_e'(kind_i)) inside
            rrtt_pkg::KIND_TICK: begin
              if (used_q == '0) begin
                status_d = rrtt_pkg::STAT_EMPTY;
                strobe_d = 1'b1;
              end else if (cur_valid_q) begin
                state_d = S_TICK_WB;   // current entry read is in flight
              end else begin
                scan_ctrl.start = 1'b1;
                scan_first      = '0;
                state_d         = S_TICK_SCAN;
              end
            end
            rrtt_pkg::KIND_ADD, rrtt_pkg::KIND_FORK: begin
              if (full) begin
                status_d = rrtt_pkg::STAT_FULL;
              end else if (kind_i == rrtt_pkg::KIND_FORK && !cur_valid_q) begin
                status_d = rrtt_pkg::STAT_NO_CURRENT;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = used_q[IW-1:0];
                ram_wdata = new_entry;
                if (kind_i == rrtt_pkg::KIND_FORK) begin
                  ram_wdata.parent_pid = cur_pid_q;
                end
                new_pid_d  = next_pid_q;
                next_pid_d = next_pid_q + 32'd1;
                used_d     = used_q + CW'(1);
              end
              strobe_d = 1'b1;
            end
            rrtt_pkg::KIND_EXIT: begin
              if (!cur_valid_q) begin
                status_d = rrtt_pkg::STAT_NO_CURRENT;
                strobe_d = 1'b1;
              end else if (cur_parent_q != '0) begin
                scan_ctrl.start  = 1'b1;
                scan_ctrl.by_pid = 1'b1;
                scan_ctrl.key    = cur_parent_q;
                state_d          = S_EXIT_SCAN;
              end else begin
                state_d = S_CUR_RD;
              end
            end
            rrtt_pkg::KIND_WAITPID: begin
              if (!cur_valid_q) begin
                status_d = rrtt_pkg::STAT_NO_CURRENT;
                strobe_d = 1'b1;
              end else begin
                scan_ctrl.start  = 1'b1;
                scan_ctrl.by_pid = 1'b1;
                scan_ctrl.key    = target_pid_i;
                state_d          = S_WAIT_SCAN;
              end
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end

      S_TICK_WB: begin
        ram_we = 1'b1;
        if (rd_entry.st != rrtt_pkg::TS_BLOCKED && rd_entry.st != rrtt_pkg::TS_TERMINATED) begin
          ram_wdata.st = rrtt_pkg::TS_READY;
        end
        scan_ctrl.start = 1'b1;
        scan_first      = first_after_cur;
        state_d         = S_TICK_SCAN;
      end

      S_TICK_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.found) begin
            ram_we       = 1'b1;
            ram_waddr    = scan_idx;
            ram_wdata.st = rrtt_pkg::TS_RUNNING;
            cur_valid_d  = 1'b1;
            cur_idx_d    = scan_idx;
            cur_pid_d    = rd_entry.pid;
            cur_parent_d = rd_entry.parent_pid;
          end else begin
            cur_valid_d = 1'b0;
            cur_idx_d   = '0;
            status_d    = rrtt_pkg::STAT_NONE_READY;
          end
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_EXIT_SCAN: begin
        if (scan_stat.done) begin
          // release the parent only if it waits on this very pid
          if (scan_stat.found && rd_entry.waiting && rd_entry.waited_pid == cur_pid_q) begin
            ram_we               = 1'b1;
            ram_waddr            = scan_idx;
            ram_wdata.waiting    = 1'b0;
            ram_wdata.waited_pid = '0;
          end
          state_d = S_CUR_RD;
        end
      end

      S_WAIT_SCAN: begin
        if (scan_stat.done) begin
          if (!scan_stat.found || rd_entry.st == rrtt_pkg::TS_TERMINATED) begin
            status_d = rrtt_pkg::STAT_WAIT_FAILED;
            strobe_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_CUR_RD;
          end
        end
      end

      S_CUR_RD: begin
        state_d = S_CUR_WR;
      end

      S_CUR_WR: begin
        ram_we = 1'b1;
        if (kind_q == rrtt_pkg::KIND_EXIT) begin
          ram_wdata.st = rrtt_pkg::TS_TERMINATED;
        end else begin
          ram_wdata.waiting    = 1'b1;
          ram_wdata.waited_pid = target_q;
          new_pid_d            = target_q;
        end
        strobe_d = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= rrtt_pkg::KIND_TICK;
      target_q     <= '0;
      status_q     <= rrtt_pkg::STAT_OK;
      new_pid_q    <= '0;
      strobe_q     <= 1'b0;
      used_q       <= '0;
      cur_valid_q  <= 1'b0;
      cur_idx_q    <= '0;
      cur_pid_q    <= '0;
      cur_parent_q <= '0;
      next_pid_q   <= 32'd1;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      target_q     <= target_d;
      status_q     <= status_d;
      new_pid_q    <= new_pid_d;
      strobe_q     <= strobe_d;
      used_q       <= used_d;
      cur_valid_q  <= cur_valid_d;
      cur_idx_q    <= cur_idx_d;
      cur_pid_q    <= cur_pid_d;
      cur_parent_q <= cur_parent_d;
      next_pid_q   <= next_pid_d;
    end
  end

  assign busy_o               = (state_q != S_IDLE);
  assign done_o               = strobe_q;
  assign status_o             = status_q;
  assign new_pid_o            = new_pid_q;
  assign running_valid_o      = cur_valid_q;
  assign running_index_o      = cur_valid_q ? 8'(cur_idx_q) : 8'd0;
  assign running_pid_o        = cur_valid_q ? cur_pid_q : 32'd0;
  assign running_parent_pid_o = cur_valid_q ? cur_parent_q : 32'd0;
  assign task_count_o         = 9'(used_q);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rrtt_pkg::*;

  localparam int MaxTasks = DefaultMaxTasks;
  localparam int RandomItems = 1600;
  localparam int KindCodeMax = 7;
  localparam int DrainCycles = 300;
  localparam int CycleLimit = 3000000;
  localparam int MaxPrinted = 30;

  typedef struct packed {
    status_e     status;
    logic [31:0] new_pid;
    logic        running_valid;
    logic [7:0]  running_index;
    logic [31:0] running_pid;
    logic [31:0] running_parent_pid;
    logic [8:0]  task_count;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  kind_i;
  logic [31:0] target_pid_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] new_pid_o;
  logic        running_valid_o;
  logic [7:0]  running_index_o;
  logic [31:0] running_pid_o;
  logic [31:0] running_parent_pid_o;
  logic [8:0]  task_count_o;

  // local copy of the process table
  logic [31:0] tbl_pid     [MaxTasks];
  logic [31:0] tbl_parent  [MaxTasks];
  task_state_e tbl_state   [MaxTasks];
  logic        tbl_waiting [MaxTasks];
  logic [31:0] tbl_waited  [MaxTasks];
  int          n_used = 0;
  logic        cur_valid = 1'b0;
  logic [7:0]  cur_idx = '0;
  logic [31:0] pid_ctr = 32'd1;

  sched_result_t results_due[$];
  int mismatches = 0;
  int cycles = 0;

  round_robin_task_table dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .kind_i               (kind_i),
    .target_pid_i         (target_pid_i),
    .done_o               (done_o),
    .status_o             (status_o),
    .new_pid_o            (new_pid_o),
    .running_valid_o      (running_valid_o),
    .running_index_o      (running_index_o),
    .running_pid_o        (running_pid_o),
    .running_parent_pid_o (running_parent_pid_o),
    .task_count_o         (task_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic int find_task(input logic [31:0] pid);
    for (int i = 0; i < n_used; i++)
      if (tbl_pid[i] == pid) return i;
    return -1;
  endfunction

  function automatic logic [31:0] append_task(input logic [31:0] parent);
    logic [31:0] pid;
    pid = pid_ctr;
    tbl_pid[n_used]     = pid;
    tbl_parent[n_used]  = parent;
    tbl_state[n_used]   = TS_READY;
    tbl_waiting[n_used] = 1'b0;
    tbl_waited[n_used]  = '0;
    pid_ctr = pid_ctr + 32'd1;
    n_used++;
    return pid;
  endfunction

  // apply one event to the local table, return the word the block must show
  function automatic sched_result_t advance_table(input logic [2:0] k,
                                                  input logic [31:0] tgt);
    sched_result_t res;
    status_e       st;
    logic [31:0]   given;
    int            idx;
    int            n;
    int            t;
    int            p;
    logic          found;
    st = STAT_OK;
    given = '0;
    case (k)
      KIND_TICK: begin
        if (n_used == 0) begin
          st = STAT_EMPTY;
        end else begin
          if (cur_valid) begin
            if (tbl_state[cur_idx] != TS_BLOCKED && tbl_state[cur_idx] != TS_TERMINATED)
              tbl_state[cur_idx] = TS_READY;
            idx = int'(cur_idx) + 1;
          end else begin
            idx = 0;
          end
          found = 1'b0;
          for (n = 0; n < n_used && !found; n++) begin
            if (idx >= n_used) idx = 0;
            if (tbl_state[idx] == TS_READY && !tbl_waiting[idx]) begin
              tbl_state[idx] = TS_RUNNING;
              cur_idx = idx[7:0];
              cur_valid = 1'b1;
              found = 1'b1;
            end else begin
              idx++;
            end
          end
          if (!found) begin
            cur_valid = 1'b0;
            cur_idx = '0;
            st = STAT_NONE_READY;
          end
        end
      end
      KIND_ADD: begin
        if (n_used >= MaxTasks) st = STAT_FULL;
        else given = append_task('0);
      end
      KIND_FORK: begin
        if (n_used >= MaxTasks) st = STAT_FULL;
        else if (!cur_valid) st = STAT_NO_CURRENT;
        else given = append_task(tbl_pid[cur_idx]);
      end
      KIND_EXIT: begin
        if (!cur_valid) begin
          st = STAT_NO_CURRENT;
        end else begin
          if (tbl_parent[cur_idx] != '0) begin
            p = find_task(tbl_parent[cur_idx]);
            if (p >= 0 && tbl_waiting[p] && tbl_waited[p] == tbl_pid[cur_idx]) begin
              tbl_waiting[p] = 1'b0;
              tbl_waited[p] = '0;
            end
          end
          tbl_state[cur_idx] = TS_TERMINATED;
        end
      end
      KIND_WAITPID: begin
        if (!cur_valid) begin
          st = STAT_NO_CURRENT;
        end else begin
          t = find_task(tgt);
          if (t < 0 || tbl_state[t] == TS_TERMINATED) begin
            st = STAT_WAIT_FAILED;
          end else begin
            tbl_waiting[cur_idx] = 1'b1;
            tbl_waited[cur_idx] = tgt;
            given = tgt;
          end
        end
      end
      default: ;
    endcase
    res.status             = st;
    res.new_pid            = given;
    res.running_valid      = cur_valid;
    res.running_index      = cur_valid ? cur_idx : '0;
    res.running_pid        = cur_valid ? tbl_pid[cur_idx] : '0;
    res.running_parent_pid = cur_valid ? tbl_parent[cur_idx] : '0;
    res.task_count         = n_used[8:0];
    return res;
  endfunction

  function automatic int pick_gap(input logic burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly a live child of the running task so waiting tasks get released
  function automatic logic [31:0] pick_wait_target();
    int kids[$];
    int r;
    r = $urandom_range(0, 99);
    if (cur_valid)
      for (int i = 0; i < n_used; i++)
        if (tbl_parent[i] == tbl_pid[cur_idx] && tbl_state[i] != TS_TERMINATED)
          kids.push_back(i);
    if (r < 60 && kids.size() > 0) return tbl_pid[kids[$urandom_range(0, kids.size() - 1)]];
    if (r < 82 && n_used > 0) return tbl_pid[$urandom_range(0, n_used - 1)];
    if (r < 94) return $urandom();
    return $urandom_range(0, pid_ctr + 1);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_cmd(input logic [2:0] k, input logic [31:0] tgt, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    kind_i       <= k;
    target_pid_i <= tgt;
    do @(posedge clk_i); while (busy_o);
    results_due.push_back(advance_table(k, tgt));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = results_due.pop_front();
        check_field("status", status_o, want.status);
        check_field("new_pid", new_pid_o, want.new_pid);
        check_field("running_valid", running_valid_o, want.running_valid);
        check_field("running_index", running_index_o, want.running_index);
        check_field("running_pid", running_pid_o, want.running_pid);
        check_field("running_parent_pid", running_parent_pid_o, want.running_parent_pid);
        check_field("task_count", task_count_o, want.task_count);
      end
    end
  end

  task automatic test_empty_table();
    issue_cmd(KIND_TICK, '0, pick_gap(1'b0));
    issue_cmd(KIND_FORK, '1, pick_gap(1'b0));
    issue_cmd(KIND_EXIT, '0, pick_gap(1'b0));
    issue_cmd(KIND_WAITPID, '0, pick_gap(1'b0));
    issue_cmd(3'(int'(KIND_WAITPID) + 1), '1, pick_gap(1'b0));
    issue_cmd(3'(KindCodeMax), '1, pick_gap(1'b0));
  endtask

  // first tick starts at index 0, later ticks wrap within the used entries
  task automatic test_round_robin();
    repeat (3) issue_cmd(KIND_ADD, $urandom(), pick_gap(1'b0));
    repeat (4) issue_cmd(KIND_TICK, $urandom(), pick_gap(1'b0));
  endtask

  task automatic test_wait_and_exit();
    logic [31:0] child;
    child = pid_ctr;
    issue_cmd(KIND_FORK, '0, pick_gap(1'b0));
    issue_cmd(KIND_WAITPID, child, pick_gap(1'b0));
    issue_cmd(KIND_WAITPID, '1, pick_gap(1'b0));
    // waiting parent is skipped until the child runs and exits
    repeat (3) issue_cmd(KIND_TICK, '0, pick_gap(1'b0));
    issue_cmd(KIND_EXIT, '0, pick_gap(1'b0));
    issue_cmd(KIND_WAITPID, child, pick_gap(1'b0));
    issue_cmd(KIND_TICK, '0, pick_gap(1'b0));
  endtask

  task automatic test_none_ready();
    repeat (3) begin
      issue_cmd(KIND_EXIT, '0, pick_gap(1'b0));
      issue_cmd(KIND_TICK, '0, pick_gap(1'b0));
    end
    issue_cmd(KIND_EXIT, '0, pick_gap(1'b0));
  endtask

  task automatic test_random_events();
    int          i;
    int          r;
    logic [2:0]  k;
    logic [31:0] tgt;
    logic        burst;
    burst = 1'b0;
    for (i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      tgt = $urandom();
      if (r < 34) k = KIND_TICK;
      else if (r < 44) k = KIND_ADD;
      else if (r < 54) k = KIND_FORK;
      else if (r < 67) k = KIND_EXIT;
      else if (r < 96) begin
        k = KIND_WAITPID;
        tgt = pick_wait_target();
      end else k = 3'($urandom_range(int'(KIND_WAITPID) + 1, KindCodeMax));
      issue_cmd(k, tgt, pick_gap(burst));
    end
  endtask

  task automatic test_table_full();
    while (n_used < MaxTasks) issue_cmd(KIND_ADD, $urandom(), pick_gap(1'b0));
    issue_cmd(KIND_ADD, '0, pick_gap(1'b0));
    issue_cmd(KIND_FORK, '0, pick_gap(1'b0));
    issue_cmd(KIND_TICK, '0, pick_gap(1'b0));
    issue_cmd(KIND_WAITPID, pid_ctr - 32'd1, pick_gap(1'b0));
    issue_cmd(KIND_TICK, '0, pick_gap(1'b0));
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = KIND_TICK;
    target_pid_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_round_robin();
    test_wait_and_exit();
    test_none_ready();
    test_random_events();
    test_table_full();
    start_i <= 1'b0;
    wait (results_due.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
